### hdl/ldtc_pkg.sv
// Shared types, CORDIC constants and arctangent table for the link distance and cost pipeline.
`default_nettype none

package ldtc_pkg;

    // CORDIC datapath word: Q2.30 angles and coordinates with headroom
    localparam int CW = 34;
    typedef logic signed [CW-1:0] cword_t;

    localparam int LANES = 3;       // colatitude A, colatitude B, longitude difference
    localparam int ATAN_N = 32;

    localparam int RAD_W  = 62;     // square root radicand width
    localparam int ROOT_W = 31;     // square root result width, one bit per cell
    localparam int REM_W  = 35;     // partial remainder width

    localparam cword_t GAIN_Q30    = 34'sd652032874;
    localparam cword_t HALF_PI_Q30 = 34'sd1686629713;
    localparam cword_t PI_Q30      = 34'sd3373259426;

    localparam cword_t ATAN_Q30 [ATAN_N] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
        34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
        34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1023,      34'sd511,       34'sd255,       34'sd127,
        34'sd63,        34'sd31,        34'sd15,        34'sd8,
        34'sd4,         34'sd2,         34'sd1,         34'sd0
    };

    typedef struct packed {
        cword_t x;
        cword_t y;
        cword_t z;
        logic   flip;   // negate cosine at the end of the rotation
    } rot_lane_t;

    typedef rot_lane_t [LANES-1:0] rot_bus_t;

    typedef struct packed {
        cword_t x;
        cword_t y;
        cword_t z;
    } vec_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    // Per-item sideband that rides along every stage
    typedef struct packed {
        logic        mode;
        logic [14:0] brk;
        logic [23:0] fixed;
        logic [15:0] near;
        logic [15:0] far;
        logic [31:0] aux;   // grid quotient, cosine term, or grid distance
    } side_t;

endpackage

`default_nettype wire

### hdl/ldtc_rot_cell.sv
// One rotation-mode CORDIC cell: advances sine/cosine of three angles by one micro-rotation.
`default_nettype none

module ldtc_rot_cell #(
    parameter int unsigned STAGE_IDX = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire ldtc_pkg::rot_bus_t in_lanes,
    input  wire ldtc_pkg::side_t   in_side,
    output logic                   out_valid,
    output ldtc_pkg::rot_bus_t     out_lanes,
    output ldtc_pkg::side_t        out_side
);

    logic               valid_reg;
    ldtc_pkg::rot_bus_t lanes_reg;
    ldtc_pkg::rot_bus_t lanes_next;
    ldtc_pkg::side_t    side_reg;

    always_comb begin
        ldtc_pkg::cword_t dx;
        ldtc_pkg::cword_t dy;
        lanes_next = in_lanes;
        for (int k = 0; k < ldtc_pkg::LANES; k++) begin
            dx = in_lanes[k].y >>> STAGE_IDX;
            dy = in_lanes[k].x >>> STAGE_IDX;
            if (in_lanes[k].z >= 0) begin
                lanes_next[k].x = in_lanes[k].x - dx;
                lanes_next[k].y = in_lanes[k].y + dy;
                lanes_next[k].z = in_lanes[k].z - ldtc_pkg::ATAN_Q30[STAGE_IDX];
            end else begin
                lanes_next[k].x = in_lanes[k].x + dx;
                lanes_next[k].y = in_lanes[k].y - dy;
                lanes_next[k].z = in_lanes[k].z + ldtc_pkg::ATAN_Q30[STAGE_IDX];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lanes_reg <= lanes_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

### hdl/ldtc_sqrt_cell.sv
// One restoring square root cell: resolves one result bit from two radicand bits.
`default_nettype none

module ldtc_sqrt_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire ldtc_pkg::sqrt_t in_sq,
    input  wire ldtc_pkg::side_t in_side,
    output logic                 out_valid,
    output ldtc_pkg::sqrt_t      out_sq,
    output ldtc_pkg::side_t      out_side
);

    localparam int RW = ldtc_pkg::REM_W;
    localparam int QW = ldtc_pkg::ROOT_W;
    localparam int DW = ldtc_pkg::RAD_W;

    logic            valid_reg;
    ldtc_pkg::sqrt_t sq_reg;
    ldtc_pkg::sqrt_t sq_next;
    ldtc_pkg::side_t side_reg;

    always_comb begin
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic          take;
        rem_sh = {in_sq.rem[RW-3:0], in_sq.rad[DW-1 -: 2]};
        trial  = {{(RW-QW-2){1'b0}}, in_sq.root, 2'b01};
        take   = (rem_sh >= trial);
        sq_next.rad  = {in_sq.rad[DW-3:0], 2'b00};
        sq_next.rem  = take ? (rem_sh - trial) : rem_sh;
        sq_next.root = {in_sq.root[QW-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg   <= sq_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_sq    = sq_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

### hdl/ldtc_vec_cell.sv
// One vectoring-mode CORDIC cell: drives y toward zero and accumulates the arc angle.
`default_nettype none

module ldtc_vec_cell #(
    parameter int unsigned STAGE_IDX = 0
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire ldtc_pkg::vec_t  in_vec,
    input  wire ldtc_pkg::side_t in_side,
    output logic                 out_valid,
    output ldtc_pkg::vec_t       out_vec,
    output ldtc_pkg::side_t      out_side
);

    logic            valid_reg;
    ldtc_pkg::vec_t  vec_reg;
    ldtc_pkg::vec_t  vec_next;
    ldtc_pkg::side_t side_reg;

    always_comb begin
        ldtc_pkg::cword_t dx;
        ldtc_pkg::cword_t dy;
        dx = in_vec.y >>> STAGE_IDX;
        dy = in_vec.x >>> STAGE_IDX;
        if (in_vec.y >= 0) begin
            vec_next.x = in_vec.x + dx;
            vec_next.y = in_vec.y - dy;
            vec_next.z = in_vec.z + ldtc_pkg::ATAN_Q30[STAGE_IDX];
        end else begin
            vec_next.x = in_vec.x - dx;
            vec_next.y = in_vec.y + dy;
            vec_next.z = in_vec.z - ldtc_pkg::ATAN_Q30[STAGE_IDX];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

### hdl/link_distance_tariff_cost.sv
// Top level: link distance (grid or great-circle) and piecewise linear tariff cost pipeline.
`default_nettype none

// Takes one item (two points and a tariff record) per clock and returns one
// result item per input item, in order. Every item flows through the same
// pipeline from s_ acceptance to m_tvalid: the angle reduction and radian
// scaling stages, a chain of CORDIC_STAGES rotation cells that produces sine
// and cosine of both colatitudes and of the longitude difference at once, the
// cosine law product registers c1..c4, 31 square root cells (one result bit
// each), CORDIC_STAGES vectoring cells for the arccosine, and the kilometre
// scaling and tariff registers f1..f5 ahead of the output register.
// Grid mode rides the same pipeline and uses the shared square root chain.
// Throughput is one item per cycle; the whole pipeline holds only while a
// finished result waits at m_ and m_tready is low. The user writes
// coordinate_mode through cfg_wr_en/cfg_wr_data only while the pipeline is
// empty; the block does not enforce it. Each item latches the mode on entry.
module link_distance_tariff_cost #(
    parameter int CORDIC_STAGES = 24
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_wr_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [14:0] point_a_first, [29:15] point_a_second, [44:30] point_b_first,
    // [59:45] point_b_second, [74:60] break_distance, [98:75] fixed charge,
    // [114:99] rate_near, [130:115] rate_far, [135:131] zero
    input  wire logic [135:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [14:0] link_distance, [45:15] link_cost, [46] cost_saturated, [47] zero
    output logic [47:0]       m_tdata
);

    localparam int L = ldtc_pkg::LANES;

    // floor(|a| * pi_q30 / 10800) = |a|*INT_PART + floor(|a|*FRAC_NUM / 5400)
    localparam logic [31:0] RAD_INT_PART = 32'd312338;
    localparam logic [31:0] RAD_FRAC_NUM = 32'd4513;
    localparam logic [50:0] DIV5400_RECIP = 51'd50903317;     // 2^38 / 5400, rounded up
    localparam logic [61:0] DIV10_RECIP   = 62'd1717986919;   // 2^34 / 10, rounded up
    localparam logic [47:0] EARTH_KM      = 48'd40077;
    localparam logic [47:0] TWO_PI_RECIP  = 48'd41721;        // 2^48 / (2*pi_q30), floored
    localparam logic [48:0] TWO_PI_Q30    = 49'd6746518852;
    localparam logic [34:0] TWO_PI_R      = 35'd6746518852;
    localparam logic [34:0] FOUR_PI_R     = 35'd13493037704;
    localparam logic [30:0] COST_MAX      = 31'h7FFF_FFFF;

    // Whole pipeline advances unless a result is held at the output
    logic adv;
    logic mode_reg;

    logic m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    // ---------------- stage 1: capture item ----------------
    logic                     v1_reg;
    ldtc_pkg::side_t          side1_reg;
    logic signed [14:0]       pa1_reg, pa2_reg, pb1_reg, pb2_reg;
    ldtc_pkg::side_t          side1_next;

    always_comb begin
        side1_next.mode  = mode_reg;
        side1_next.brk   = s_tdata[74:60];
        side1_next.fixed = s_tdata[98:75];
        side1_next.near  = s_tdata[114:99];
        side1_next.far   = s_tdata[130:115];
        side1_next.aux   = 32'd0;
    end

    // ---------------- stage 2: angle reduction and grid squares ----------------
    logic                     v2_reg;
    ldtc_pkg::side_t          side2_reg;
    logic signed [13:0]       fold2_reg [L];
    logic                     flip2_reg [L];
    logic [30:0]              sqsum2_reg;
    logic signed [13:0]       fold2_next [L];
    logic                     flip2_next [L];
    logic [30:0]              sqsum2_next;

    always_comb begin
        logic signed [17:0] ang [L];
        logic signed [17:0] r;
        logic signed [15:0] dv;
        logic signed [15:0] dh;
        logic [31:0]        sqv;
        logic [31:0]        sqh;
        // colatitudes and longitude difference, in arc-minutes
        ang[0] = 18'sd5400 - 18'(pa1_reg);
        ang[1] = 18'sd5400 - 18'(pb1_reg);
        ang[2] = 18'(pa2_reg) - 18'(pb2_reg);
        for (int k = 0; k < L; k++) begin
            r = ang[k];
            // wrap into (-half turn, half turn]
            if (r < -18'sd21600) begin
                r = r + 18'sd43200;
            end else if (r < 18'sd0) begin
                r = r + 18'sd21600;
            end
            if (r >= 18'sd21600) begin
                r = r - 18'sd21600;
            end
            if (r > 18'sd10800) begin
                r = r - 18'sd21600;
            end
            // fold into one half-plane; cosine changes sign
            flip2_next[k] = 1'b0;
            if (r > 18'sd5400) begin
                r = 18'sd10800 - r;
                flip2_next[k] = 1'b1;
            end else if (r < -18'sd5400) begin
                r = -18'sd10800 - r;
                flip2_next[k] = 1'b1;
            end
            fold2_next[k] = 14'(r);
        end
        dv = 16'(pa1_reg) - 16'(pb1_reg);
        dh = 16'(pa2_reg) - 16'(pb2_reg);
        sqv = 32'(dv) * 32'(dv);
        sqh = 32'(dh) * 32'(dh);
        sqsum2_next = 31'(sqv + sqh);
    end

    // ---------------- stage 3: radian scaling products, grid divide by ten ----------------
    logic                     v3_reg;
    ldtc_pkg::side_t          side3_reg;
    logic [30:0]              mint3_reg [L];
    logic [24:0]              mfn3_reg [L];
    logic                     neg3_reg [L];
    logic                     flip3_reg [L];
    logic [30:0]              mint3_next [L];
    logic [24:0]              mfn3_next [L];
    logic                     neg3_next [L];
    ldtc_pkg::side_t          side3_next;

    always_comb begin
        logic [12:0] absf;
        logic [61:0] gprod;
        for (int k = 0; k < L; k++) begin
            neg3_next[k] = fold2_reg[k] < 14'sd0;
            absf = 13'(neg3_next[k] ? -fold2_reg[k] : fold2_reg[k]);
            mint3_next[k] = 31'(32'(absf) * RAD_INT_PART);
            mfn3_next[k]  = 25'(32'(absf) * RAD_FRAC_NUM);
        end
        gprod = 62'(sqsum2_reg) * DIV10_RECIP;
        side3_next = side2_reg;
        side3_next.aux = 32'(gprod[61:34]);
    end

    // ---------------- stage 4: fractional part of radians ----------------
    logic                     v4_reg;
    ldtc_pkg::side_t          side4_reg;
    logic [30:0]              mint4_reg [L];
    logic [12:0]              frac4_reg [L];
    logic                     neg4_reg [L];
    logic                     flip4_reg [L];
    logic [12:0]              frac4_next [L];

    always_comb begin
        logic [50:0] fp;
        for (int k = 0; k < L; k++) begin
            fp = 51'(mfn3_reg[k]) * DIV5400_RECIP;
            frac4_next[k] = 13'(fp[50:38]);
        end
    end

    // ---------------- rotation CORDIC chain ----------------
    ldtc_pkg::rot_bus_t rot_lanes [CORDIC_STAGES+1];
    ldtc_pkg::side_t    rot_side  [CORDIC_STAGES+1];
    logic               rot_valid [CORDIC_STAGES+1];

    always_comb begin
        logic [31:0]      zsum;
        ldtc_pkg::cword_t zs;
        for (int k = 0; k < L; k++) begin
            zsum = 32'(mint4_reg[k]) + 32'(frac4_reg[k]);
            zs = $signed(34'(zsum));
            rot_lanes[0][k].x    = ldtc_pkg::GAIN_Q30;
            rot_lanes[0][k].y    = '0;
            rot_lanes[0][k].z    = neg4_reg[k] ? -zs : zs;
            rot_lanes[0][k].flip = flip4_reg[k];
        end
    end
    assign rot_side[0]  = side4_reg;
    assign rot_valid[0] = v4_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
        ldtc_rot_cell #(
            .STAGE_IDX(g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .in_valid (rot_valid[g]),
            .in_lanes (rot_lanes[g]),
            .in_side  (rot_side[g]),
            .out_valid(rot_valid[g+1]),
            .out_lanes(rot_lanes[g+1]),
            .out_side (rot_side[g+1])
        );
    end

    // ---------------- cosine law: c1..c4 ----------------
    logic                 vc1_reg, vc2_reg, vc3_reg, vc4_reg;
    ldtc_pkg::side_t      sidec1_reg, sidec2_reg, sidec3_reg, sidec4_reg;
    logic signed [63:0]   p1_reg, p2_reg, p1c2_reg, p3_reg;
    logic signed [31:0]   cw1_reg;
    logic [61:0]          rad4_reg;
    logic signed [63:0]   p1_next, p2_next, p3_next;
    logic signed [31:0]   cw1_next;
    ldtc_pkg::side_t      sidec3_next;
    logic [61:0]          rad4_next;

    always_comb begin
        logic signed [31:0] cs [L];
        logic signed [31:0] sn [L];
        for (int k = 0; k < L; k++) begin
            cs[k] = 32'(rot_lanes[CORDIC_STAGES][k].flip ? -rot_lanes[CORDIC_STAGES][k].x
                                                         : rot_lanes[CORDIC_STAGES][k].x);
            sn[k] = 32'(rot_lanes[CORDIC_STAGES][k].y);
        end
        p1_next  = 64'(cs[1]) * 64'(cs[0]);
        p2_next  = 64'(sn[1]) * 64'(sn[0]);
        cw1_next = cs[2];
    end

    always_comb begin
        logic signed [31:0] t;
        t = 32'(p2_reg >>> 30);
        p3_next = 64'(t) * 64'(cw1_reg);
    end

    always_comb begin
        logic signed [64:0] sum;
        logic signed [64:0] sh;
        logic signed [31:0] c;
        sum = 65'(p1c2_reg) + 65'(p3_reg);
        sh  = sum >>> 30;
        if (sh > 65'sd1073741824) begin
            c = 32'sd1073741824;
        end else if (sh < -65'sd1073741824) begin
            c = -32'sd1073741824;
        end else begin
            c = 32'(sh);
        end
        sidec3_next = sidec2_reg;
        // grid items keep their quotient in aux
        if (sidec2_reg.mode) begin
            sidec3_next.aux = c;
        end
    end

    always_comb begin
        logic signed [31:0] c;
        logic signed [63:0] csq;
        c   = $signed(sidec3_reg.aux);
        csq = 64'(c) * 64'(c);
        if (sidec3_reg.mode) begin
            rad4_next = 62'(64'sd1152921504606846976 - csq);
        end else begin
            rad4_next = 62'(sidec3_reg.aux);
        end
    end

    // ---------------- square root chain ----------------
    ldtc_pkg::sqrt_t sq_bus   [ldtc_pkg::ROOT_W+1];
    ldtc_pkg::side_t sq_side  [ldtc_pkg::ROOT_W+1];
    logic            sq_valid [ldtc_pkg::ROOT_W+1];

    assign sq_bus[0]   = '{rad: rad4_reg, rem: '0, root: '0};
    assign sq_side[0]  = sidec4_reg;
    assign sq_valid[0] = vc4_reg;

    for (genvar g = 0; g < ldtc_pkg::ROOT_W; g++) begin : g_sqrt
        ldtc_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .in_valid (sq_valid[g]),
            .in_sq    (sq_bus[g]),
            .in_side  (sq_side[g]),
            .out_valid(sq_valid[g+1]),
            .out_sq   (sq_bus[g+1]),
            .out_side (sq_side[g+1])
        );
    end

    // ---------------- arccosine vectoring chain ----------------
    ldtc_pkg::vec_t  vc_bus   [CORDIC_STAGES+1];
    ldtc_pkg::side_t vc_side  [CORDIC_STAGES+1];
    logic            vc_valid [CORDIC_STAGES+1];

    always_comb begin
        logic signed [31:0] c;
        ldtc_pkg::cword_t   s;
        ldtc_pkg::cword_t   cx;
        c  = $signed(sq_side[ldtc_pkg::ROOT_W].aux);
        s  = $signed(34'(sq_bus[ldtc_pkg::ROOT_W].root));
        cx = 34'(c);
        // negative cosine: pre-rotate by a quarter turn
        if (c < 32'sd0) begin
            vc_bus[0].x = s;
            vc_bus[0].y = -cx;
            vc_bus[0].z = ldtc_pkg::HALF_PI_Q30;
        end else begin
            vc_bus[0].x = cx;
            vc_bus[0].y = s;
            vc_bus[0].z = '0;
        end
        vc_side[0] = sq_side[ldtc_pkg::ROOT_W];
        if (!sq_side[ldtc_pkg::ROOT_W].mode) begin
            vc_side[0].aux = 32'(sq_bus[ldtc_pkg::ROOT_W].root);
        end
    end
    assign vc_valid[0] = sq_valid[ldtc_pkg::ROOT_W];

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
        ldtc_vec_cell #(
            .STAGE_IDX(g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .in_valid (vc_valid[g]),
            .in_vec   (vc_bus[g]),
            .in_side  (vc_side[g]),
            .out_valid(vc_valid[g+1]),
            .out_vec  (vc_bus[g+1]),
            .out_side (vc_side[g+1])
        );
    end

    // ---------------- kilometre scaling f1..f4, tariff f5 ----------------
    logic              vf1_reg, vf2_reg, vf3_reg, vf4_reg, vf5_reg;
    ldtc_pkg::side_t   sidef1_reg, sidef2_reg, sidef3_reg, sidef4_reg, sidef5_reg;
    logic [47:0]       prod1_reg, prod2_reg;
    logic [15:0]       qe2_reg, qe3_reg;
    logic [34:0]       r3_reg;
    logic [14:0]       d4_reg, d5_reg;
    logic [30:0]       mn5_reg, mf5_reg;
    logic [47:0]       prod1_next;
    logic [15:0]       qe2_next;
    logic [34:0]       r3_next;
    logic [14:0]       d4_next;
    logic [30:0]       mn5_next, mf5_next;
    logic [47:0]       m_tdata_next;

    always_comb begin
        ldtc_pkg::cword_t z;
        logic [31:0]      zc;
        z = vc_bus[CORDIC_STAGES].z;
        if (z < 0) begin
            zc = 32'd0;
        end else if (z > ldtc_pkg::PI_Q30) begin
            zc = 32'(ldtc_pkg::PI_Q30);
        end else begin
            zc = 32'(z);
        end
        prod1_next = 48'(zc) * EARTH_KM;
    end

    always_comb begin
        logic [47:0] qp;
        qp = 48'(prod1_reg[47:16]) * TWO_PI_RECIP;
        qe2_next = 16'(qp[47:32]);
    end

    always_comb begin
        logic [48:0] qd;
        qd = 49'(qe2_reg) * TWO_PI_Q30;
        r3_next = 35'(49'(prod2_reg) - qd);
    end

    always_comb begin
        logic [15:0] q;
        // the estimate runs at most two short of the quotient
        q = qe3_reg + 16'(r3_reg >= TWO_PI_R) + 16'(r3_reg >= FOUR_PI_R);
        d4_next = sidef3_reg.mode ? 15'(q) : sidef3_reg.aux[14:0];
    end

    always_comb begin
        logic [14:0] dmin;
        logic [14:0] dfar;
        if (d4_reg <= sidef4_reg.brk) begin
            dmin = d4_reg;
            dfar = 15'd0;
        end else begin
            dmin = sidef4_reg.brk;
            dfar = d4_reg - sidef4_reg.brk;
        end
        mn5_next = 31'(32'(sidef4_reg.near) * 32'(dmin));
        mf5_next = 31'(32'(sidef4_reg.far) * 32'(dfar));
    end

    always_comb begin
        logic [32:0] total;
        logic        sat;
        total = 33'(sidef5_reg.fixed) + 33'(mn5_reg) + 33'(mf5_reg);
        sat   = |total[32:31];
        m_tdata_next = {1'b0, sat, (sat ? COST_MAX : total[30:0]), d5_reg};
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            vc1_reg      <= 1'b0;
            vc2_reg      <= 1'b0;
            vc3_reg      <= 1'b0;
            vc4_reg      <= 1'b0;
            vf1_reg      <= 1'b0;
            vf2_reg      <= 1'b0;
            vf3_reg      <= 1'b0;
            vf4_reg      <= 1'b0;
            vf5_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            vc1_reg      <= rot_valid[CORDIC_STAGES];
            vc2_reg      <= vc1_reg;
            vc3_reg      <= vc2_reg;
            vc4_reg      <= vc3_reg;
            vf1_reg      <= vc_valid[CORDIC_STAGES];
            vf2_reg      <= vf1_reg;
            vf3_reg      <= vf2_reg;
            vf4_reg      <= vf3_reg;
            vf5_reg      <= vf4_reg;
            m_tvalid_reg <= vf5_reg;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            side1_reg  <= side1_next;
            pa1_reg    <= s_tdata[14:0];
            pa2_reg    <= s_tdata[29:15];
            pb1_reg    <= s_tdata[44:30];
            pb2_reg    <= s_tdata[59:45];

            side2_reg  <= side1_reg;
            sqsum2_reg <= sqsum2_next;
            side3_reg  <= side3_next;
            side4_reg  <= side3_reg;
            for (int k = 0; k < L; k++) begin
                fold2_reg[k] <= fold2_next[k];
                flip2_reg[k] <= flip2_next[k];
                mint3_reg[k] <= mint3_next[k];
                mfn3_reg[k]  <= mfn3_next[k];
                neg3_reg[k]  <= neg3_next[k];
                flip3_reg[k] <= flip2_reg[k];
                mint4_reg[k] <= mint3_reg[k];
                frac4_reg[k] <= frac4_next[k];
                neg4_reg[k]  <= neg3_reg[k];
                flip4_reg[k] <= flip3_reg[k];
            end

            sidec1_reg <= rot_side[CORDIC_STAGES];
            p1_reg     <= p1_next;
            p2_reg     <= p2_next;
            cw1_reg    <= cw1_next;
            sidec2_reg <= sidec1_reg;
            p1c2_reg   <= p1_reg;
            p3_reg     <= p3_next;
            sidec3_reg <= sidec3_next;
            sidec4_reg <= sidec3_reg;
            rad4_reg   <= rad4_next;

            sidef1_reg <= vc_side[CORDIC_STAGES];
            prod1_reg  <= prod1_next;
            sidef2_reg <= sidef1_reg;
            prod2_reg  <= prod1_reg;
            qe2_reg    <= qe2_next;
            sidef3_reg <= sidef2_reg;
            qe3_reg    <= qe2_reg;
            r3_reg     <= r3_next;
            sidef4_reg <= sidef3_reg;
            d4_reg     <= d4_next;
            sidef5_reg <= sidef4_reg;
            d5_reg     <= d4_reg;
            mn5_reg    <= mn5_next;
            mf5_reg    <= mf5_next;

            m_tdata_reg <= m_tdata_next;
        end
    end

`ifndef ASSERT_OFF
    // A clamped cost always reads as the largest cost
    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[46] |-> m_tdata[45:15] == COST_MAX)
        else $error("saturated cost is not the maximum");

    // An accepted item enters the first stage
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted item lost at entry");

    // Reset empties the output register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
`endif

endmodule

`default_nettype wire
